// ----- rtl/core/rhg_pkg.sv -----
package rhg_pkg;

  // default parameter values
  localparam int DEF_BLOCK_SIZE     = 64;
  localparam int DEF_MAX_ROWS       = 32;
  localparam int DEF_MAX_COLS       = 32;
  localparam int DEF_SCREEN_COLUMNS = 320;
  localparam int DEF_FOV_DEGREES    = 60;

  // field widths
  localparam int POS_W  = 12;
  localparam int HD_W   = 13;
  localparam int SC_W   = 9;
  localparam int CELL_W = 5;
  localparam int DIST_W = 24;
  localparam int CFG_W  = 6;
  localparam int DIM_W  = 9;   // map_rows / map_cols after clamping (up to 511)

  // register indexes
  localparam logic REG_MAP_ROWS = 1'b0;
  localparam logic REG_MAP_COLS = 1'b1;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // angles in 1/16 degree
  localparam int QUARTER   = 1440;
  localparam int FULL_TURN = 5760;
  localparam int PHI_W     = 11;
  localparam int RAY_W     = 13;

  // mod FULL_TURN by reciprocal multiply
  localparam int SUM_W = 22;
  localparam int SH2   = 35;
  localparam longint unsigned M2 = ((64'd1 << SH2) + FULL_TURN - 1) / FULL_TURN;
  localparam int M2_W  = 23;
  localparam int W_W   = 10;

  // distance accumulators
  localparam int ACC_W = 50;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // trig rom: {sec, tan}, both Q16.16
  typedef logic [63:0] trig_word_t;
  typedef trig_word_t trig_rom_t [QUARTER];

  localparam logic [63:0] STEP_COS = 64'd2147482370;
  localparam logic [63:0] STEP_SIN = 64'd2342541;

  // restoring divide, evaluated at elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] qq;
    logic [63:0] rr;
    qq = '0;
    rr = '0;
    for (int k = 63; k >= 0; k--) begin
      rr = {rr[62:0], n[k]};
      if (rr >= d) begin
        rr = rr - d;
        qq[k] = 1'b1;
      end
    end
    return qq;
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // rotate (1,0) in 1/16 degree steps, Q1.31
  function automatic trig_rom_t build_trig();
    trig_rom_t   rom;
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] q;
    c = 64'd1 << 31;
    s = '0;
    for (int k = 0; k < QUARTER; k++) begin
      if (c == 0) begin
        rom[k] = '1;
      end else begin
        rom[k] = {sat32(udiv64(64'd1 << 47, c)), sat32(udiv64(s << 16, c))};
      end
      a = c * STEP_COS;
      b = s * STEP_SIN;
      q = (s * STEP_COS + c * STEP_SIN + (64'd1 << 30)) >> 31;
      c = (a >= b) ? ((a - b + (64'd1 << 30)) >> 31) : 64'd0;
      s = q;
    end
    return rom;
  endfunction

endpackage

// ----- rtl/core/rhg_trig_rom.sv -----
module rhg_trig_rom (
  input  logic                           clk,
  input  logic [rhg_pkg::PHI_W-1:0]      addr,
  output rhg_pkg::trig_word_t            rdata
);

  localparam rhg_pkg::trig_rom_t TRIG = rhg_pkg::build_trig();

  // registered read
  always_ff @(posedge clk) begin
    rdata <= TRIG[addr];
  end

endmodule

// ----- rtl/core/rhg_map_ram.sv -----
module rhg_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ray_horizontal_grid_hit_top.sv -----
// Cast: after the accepting edge the sequencer runs the setup states A1 to A6 and T0, then for
// each grid line that reaches a map read it runs check, divide, read and compare, and ends with
// the out_valid strobe; a ray along the grid lines ends after A5. A write word stays in IDLE.
// One word at a time; busy stays high until a cast is done. The receiver cannot stall: out_valid
// is a one-cycle strobe. After reset (sync, active-low rst_n) the map RAM is cleared,
// one cell per cycle, all MAX_ROWS*MAX_COLS cells, with busy high; config is taken anytime.
module ray_horizontal_grid_hit_top #(
  parameter int BLOCK_SIZE     = rhg_pkg::DEF_BLOCK_SIZE,
  parameter int MAX_ROWS       = rhg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS       = rhg_pkg::DEF_MAX_COLS,
  parameter int SCREEN_COLUMNS = rhg_pkg::DEF_SCREEN_COLUMNS,
  parameter int FOV_DEGREES    = rhg_pkg::DEF_FOV_DEGREES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [rhg_pkg::CELL_W-1:0]   in_cell_row,
  input  logic [rhg_pkg::CELL_W-1:0]   in_cell_col,
  input  logic                         in_cell_wall,
  input  logic [rhg_pkg::POS_W-1:0]    in_pos_x,
  input  logic [rhg_pkg::POS_W-1:0]    in_pos_y,
  input  logic [rhg_pkg::HD_W-1:0]     in_heading,
  input  logic [rhg_pkg::SC_W-1:0]     in_screen_column,
  output logic                         out_valid,
  output logic [rhg_pkg::DIST_W-1:0]   out_distance,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [rhg_pkg::CFG_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // divide by BLOCK_SIZE: exact for operands below 2^16
  localparam int SHB   = 24;
  localparam int MB    = ((1 << SHB) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int MB_W  = 25;
  // column angle: col * FOV * 16 / SCREEN_COLUMNS
  localparam int FOVK  = FOV_DEGREES * 16;
  localparam int P_W   = 21;
  localparam int SH1   = 33;
  localparam longint unsigned M1 = ((64'd1 << SH1) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;
  localparam int M1_W  = 34;
  localparam int BW    = 9;
  localparam int LW    = 13;
  localparam int IW    = 17;
  localparam int XW    = rhg_pkg::ACC_W + 1;
  localparam int IFW   = XW - 16;
  localparam int CWW   = 18;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_A1   = 4'd2;
  localparam logic [3:0] S_A2   = 4'd3;
  localparam logic [3:0] S_A3   = 4'd4;
  localparam logic [3:0] S_A4   = 4'd5;
  localparam logic [3:0] S_A5   = 4'd6;
  localparam logic [3:0] S_A6   = 4'd7;
  localparam logic [3:0] S_T0   = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_RD   = 4'd11;
  localparam logic [3:0] S_WT   = 4'd12;

  logic [3:0]                       state_r, state_nxt;
  logic [AW-1:0]                    clr_cnt_r, clr_cnt_nxt;
  logic [rhg_pkg::DIM_W-1:0]        rows_r, cols_r;
  logic [rhg_pkg::POS_W-1:0]        px_r, px_nxt, py_r, py_nxt;
  logic [rhg_pkg::HD_W-1:0]         hd_r, hd_nxt;
  logic [rhg_pkg::SC_W-1:0]         sc_r, sc_nxt;
  logic [P_W-1:0]                   p_r, p_nxt, qa_r, qa_nxt;
  logic [rhg_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic [rhg_pkg::W_W-1:0]          w_r, w_nxt;
  logic [rhg_pkg::POS_W-1:0]        pyq_r, pyq_nxt;
  logic [BW-1:0]                    rem_r, rem_nxt, t0_r, t0_nxt;
  logic [rhg_pkg::PHI_W-1:0]        phi_r, phi_nxt;
  logic                             up_r, up_nxt, plus_r, plus_nxt;
  logic [LW-1:0]                    l_r, l_nxt;
  logic [rhg_pkg::ACC_W-1:0]        off_r, off_nxt, dsec_r, dsec_nxt;
  logic [rhg_pkg::ACC_W-1:0]        tanb_r, tanb_nxt, secb_r, secb_nxt;
  logic [IW-1:0]                    i_r, i_nxt, colq_r, colq_nxt;
  logic [rhg_pkg::DIM_W-1:0]        row_r, row_nxt;
  logic                             rd_en_r, rd_en_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [rhg_pkg::DIST_W-1:0]       out_dist_r, out_dist_nxt;

  // datapath temporaries
  logic [P_W+M1_W-1:0]              qa_prod;
  logic [rhg_pkg::SUM_W+rhg_pkg::M2_W-1:0] w_prod;
  logic [rhg_pkg::POS_W+MB_W-1:0]   pyq_prod;
  logic [IW+MB_W-1:0]               colq_prod;
  logic [rhg_pkg::RAY_W-1:0]        ray;
  logic [1:0]                       quad;
  logic [rhg_pkg::PHI_W-1:0]        rr;
  logic [XW-1:0]                    basex, offx, ifull_w;
  logic [IFW-1:0]                   ifull;
  logic                             out_x, stop;
  logic [CWW-1:0]                   cols_w;
  logic [rhg_pkg::ACC_W-9:0]        dq;
  logic [rhg_pkg::DIST_W-1:0]       dist_sat;
  rhg_pkg::trig_word_t              trig;

  // map ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic          ram_wdata, ram_rdata;

  rhg_trig_rom u_rom (
    .clk   (clk),
    .addr  (phi_r),
    .rdata (trig)
  );

  rhg_map_ram #(.DEPTH(DEPTH), .AW(AW)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;

  // arithmetic shared by the states
  assign qa_prod   = (P_W+M1_W)'(p_r) * (P_W+M1_W)'(M1);
  assign w_prod    = (rhg_pkg::SUM_W+rhg_pkg::M2_W)'(sum_r) *
                     (rhg_pkg::SUM_W+rhg_pkg::M2_W)'(rhg_pkg::M2);
  assign pyq_prod  = (rhg_pkg::POS_W+MB_W)'(py_r) * (rhg_pkg::POS_W+MB_W)'(MB);
  assign colq_prod = (IW+MB_W)'(i_r) * (IW+MB_W)'(MB);
  assign ray       = rhg_pkg::RAY_W'(sum_r - rhg_pkg::SUM_W'(w_r) *
                                     rhg_pkg::SUM_W'(rhg_pkg::FULL_TURN));
  assign cols_w    = CWW'(cols_r) * CWW'(BLOCK_SIZE);

  // quadrant and remainder
  always_comb begin
    priority if (ray >= rhg_pkg::RAY_W'(3 * rhg_pkg::QUARTER)) begin
      quad = 2'd3;
      rr   = rhg_pkg::PHI_W'(ray - rhg_pkg::RAY_W'(3 * rhg_pkg::QUARTER));
    end else if (ray >= rhg_pkg::RAY_W'(2 * rhg_pkg::QUARTER)) begin
      quad = 2'd2;
      rr   = rhg_pkg::PHI_W'(ray - rhg_pkg::RAY_W'(2 * rhg_pkg::QUARTER));
    end else if (ray >= rhg_pkg::RAY_W'(rhg_pkg::QUARTER)) begin
      quad = 2'd1;
      rr   = rhg_pkg::PHI_W'(ray - rhg_pkg::RAY_W'(rhg_pkg::QUARTER));
    end else begin
      quad = 2'd0;
      rr   = rhg_pkg::PHI_W'(ray);
    end
  end

  // crossing x at the current line
  assign basex   = XW'(px_r) << 16;
  assign offx    = XW'(off_r);
  assign out_x   = !plus_r && (basex < offx + XW'(65536));
  assign ifull_w = plus_r ? (basex + offx) : (basex - offx);
  assign ifull   = IFW'(ifull_w >> 16);
  assign stop    = out_x || (ifull == '0) || (ifull >= IFW'(cols_w)) ||
                   (l_r == '0) || (l_r == LW'(rows_r)) ||
                   (!up_r && (l_r > LW'(rows_r)));

  // Q16.8 distance, saturated
  assign dq       = dsec_r[rhg_pkg::ACC_W-1:8];
  assign dist_sat = (dq > (rhg_pkg::ACC_W-8)'(rhg_pkg::DIST_MAX)) ?
                    rhg_pkg::DIST_MAX : rhg_pkg::DIST_W'(dq);

  // map ram write: clearing pass or write word
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = 1'b0;
    if (state_r == S_CLR) begin
      ram_we = 1'b1;
    end else if (state_r == S_IDLE && start && in_opcode == rhg_pkg::OP_WRITE &&
                 int'(in_cell_row) < MAX_ROWS && int'(in_cell_col) < MAX_COLS) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(32'(in_cell_row) * 32'(MAX_COLS) + 32'(in_cell_col));
      ram_wdata = in_cell_wall;
    end
  end

  assign ram_raddr = AW'(32'(row_r) * 32'(MAX_COLS) + 32'(colq_r));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    hd_nxt        = hd_r;
    sc_nxt        = sc_r;
    p_nxt         = p_r;
    qa_nxt        = qa_r;
    sum_nxt       = sum_r;
    w_nxt         = w_r;
    pyq_nxt       = pyq_r;
    rem_nxt       = rem_r;
    t0_nxt        = t0_r;
    phi_nxt       = phi_r;
    up_nxt        = up_r;
    plus_nxt      = plus_r;
    l_nxt         = l_r;
    off_nxt       = off_r;
    dsec_nxt      = dsec_r;
    tanb_nxt      = tanb_r;
    secb_nxt      = secb_r;
    i_nxt         = i_r;
    colq_nxt      = colq_r;
    row_nxt       = row_r;
    rd_en_nxt     = rd_en_r;
    out_valid_nxt = 1'b0;
    out_dist_nxt  = out_dist_r;
    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && in_opcode == rhg_pkg::OP_CAST) begin
          px_nxt    = in_pos_x;
          py_nxt    = in_pos_y;
          hd_nxt    = in_heading;
          sc_nxt    = in_screen_column;
          state_nxt = S_A1;
        end
      end
      S_A1: begin
        p_nxt     = P_W'(P_W'(sc_r) * P_W'(FOVK));
        pyq_nxt   = rhg_pkg::POS_W'(pyq_prod >> SHB);
        state_nxt = S_A2;
      end
      S_A2: begin
        qa_nxt    = P_W'(qa_prod >> SH1);
        rem_nxt   = BW'(py_r - rhg_pkg::POS_W'(24'(pyq_r) * 24'(BLOCK_SIZE)));
        state_nxt = S_A3;
      end
      S_A3: begin
        sum_nxt   = rhg_pkg::SUM_W'(hd_r) + rhg_pkg::SUM_W'(qa_r);
        state_nxt = S_A4;
      end
      S_A4: begin
        w_nxt     = rhg_pkg::W_W'(w_prod >> rhg_pkg::SH2);
        state_nxt = S_A5;
      end
      S_A5: begin
        // quadrant decode, first grid line
        up_nxt   = (quad == 2'd0) || (quad == 2'd3);
        plus_nxt = (quad == 2'd0) || (quad == 2'd1);
        phi_nxt  = (quad == 2'd0 || quad == 2'd2) ? rr :
                   rhg_pkg::PHI_W'(rhg_pkg::QUARTER) - rr;
        if (quad == 2'd0 || quad == 2'd3) begin
          l_nxt  = LW'(pyq_r);
          t0_nxt = rem_r;
        end else begin
          l_nxt  = LW'(pyq_r) + LW'(1);
          t0_nxt = BW'(BLOCK_SIZE) - rem_r;
        end
        if ((quad == 2'd1 || quad == 2'd3) && rr == '0) begin
          // ray along the grid lines
          out_valid_nxt = 1'b1;
          out_dist_nxt  = rhg_pkg::DIST_MAX;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_A6;
        end
      end
      S_A6: begin
        state_nxt = S_T0;
      end
      S_T0: begin
        off_nxt   = rhg_pkg::ACC_W'(t0_r) * rhg_pkg::ACC_W'(trig[31:0]);
        dsec_nxt  = rhg_pkg::ACC_W'(t0_r) * rhg_pkg::ACC_W'(trig[63:32]);
        tanb_nxt  = rhg_pkg::ACC_W'(trig[31:0]) * rhg_pkg::ACC_W'(BLOCK_SIZE);
        secb_nxt  = rhg_pkg::ACC_W'(trig[63:32]) * rhg_pkg::ACC_W'(BLOCK_SIZE);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        i_nxt     = IW'(ifull);
        row_nxt   = up_r ? rhg_pkg::DIM_W'(l_r - LW'(1)) : rhg_pkg::DIM_W'(l_r);
        rd_en_nxt = up_r ? (l_r < LW'(rows_r)) : 1'b1;
        if (stop) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_sat;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        colq_nxt  = IW'(colq_prod >> SHB);
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_WT;
      end
      S_WT: begin
        if (rd_en_r && ram_rdata) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_sat;
          state_nxt     = S_IDLE;
        end else begin
          l_nxt     = up_r ? (l_r - LW'(1)) : (l_r + LW'(1));
          off_nxt   = off_r + tanb_r;
          dsec_nxt  = dsec_r + secb_r;
          state_nxt = S_CHK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rows_r      <= rhg_pkg::DIM_W'(MAX_ROWS);
      cols_r      <= rhg_pkg::DIM_W'(MAX_COLS);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          rhg_pkg::REG_MAP_ROWS: rows_r <= (int'(cfg_data) > MAX_ROWS) ?
                                           rhg_pkg::DIM_W'(MAX_ROWS) :
                                           rhg_pkg::DIM_W'(cfg_data);
          rhg_pkg::REG_MAP_COLS: cols_r <= (int'(cfg_data) > MAX_COLS) ?
                                           rhg_pkg::DIM_W'(MAX_COLS) :
                                           rhg_pkg::DIM_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    hd_r       <= hd_nxt;
    sc_r       <= sc_nxt;
    p_r        <= p_nxt;
    qa_r       <= qa_nxt;
    sum_r      <= sum_nxt;
    w_r        <= w_nxt;
    pyq_r      <= pyq_nxt;
    rem_r      <= rem_nxt;
    t0_r       <= t0_nxt;
    phi_r      <= phi_nxt;
    up_r       <= up_nxt;
    plus_r     <= plus_nxt;
    l_r        <= l_nxt;
    off_r      <= off_nxt;
    dsec_r     <= dsec_nxt;
    tanb_r     <= tanb_nxt;
    secb_r     <= secb_nxt;
    i_r        <= i_nxt;
    colq_r     <= colq_nxt;
    row_r      <= row_nxt;
    rd_en_r    <= rd_en_nxt;
    out_dist_r <= out_dist_nxt;
  end

endmodule

// ----- dv/rhg_checker.sv -----
module rhg_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_opcode,
  input  logic [rhg_pkg::CELL_W-1:0] in_cell_row,
  input  logic [rhg_pkg::CELL_W-1:0] in_cell_col,
  input  logic                       in_cell_wall,
  input  logic [rhg_pkg::POS_W-1:0]  in_pos_x,
  input  logic [rhg_pkg::POS_W-1:0]  in_pos_y,
  input  logic [rhg_pkg::HD_W-1:0]   in_heading,
  input  logic [rhg_pkg::SC_W-1:0]   in_screen_column,
  input  logic                       out_valid,
  input  logic [rhg_pkg::DIST_W-1:0] out_distance,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [rhg_pkg::CFG_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         dist_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rhg_pkg::*;

  localparam longint BLK  = 64;
  localparam int     ROWS = 32;
  localparam int     COLS = 32;

  longint unsigned tan_lut [QUARTER];
  longint unsigned sec_lut [QUARTER];
  bit              wall_map [ROWS*COLS];
  int              rows_used;
  int              cols_used;
  logic [DIST_W-1:0] dist_q [$];

  assign dist_pending = dist_q.size();

  // tangent/secant tables from stepwise rotation in Q1.31
  initial begin
    longint unsigned c, s, a, b, nq;
    c = 64'd1 << 31;
    s = 0;
    for (int k = 0; k < QUARTER; k++) begin
      if (c == 0) begin
        tan_lut[k] = 64'hFFFF_FFFF;
        sec_lut[k] = 64'hFFFF_FFFF;
      end else begin
        nq = (s << 16) / c;
        tan_lut[k] = (nq > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nq;
        nq = (64'd1 << 47) / c;
        sec_lut[k] = (nq > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nq;
      end
      a = c * 64'd2147482370;
      b = s * 64'd2342541;
      nq = (s * 64'd2147482370 + c * 64'd2342541 + (64'd1 << 30)) >> 31;
      c = (a >= b) ? ((a - b + (64'd1 << 30)) >> 31) : 0;
      s = nq;
    end
  end

  // walk horizontal grid lines until wall, edge or x out of map
  function automatic logic [DIST_W-1:0] grid_distance(longint px, longint py,
                                                      longint hd, longint col);
    longint ray, quad, rem, phi, j, edge_y, cols_w, stp, t, off, i, base, dist_v;
    bit up, plus, out_left;
    ray  = (hd + (col * 60 * 16) / 320) % FULL_TURN;
    quad = ray / QUARTER;
    rem  = ray % QUARTER;
    if ((quad == 1 || quad == 3) && rem == 0) return DIST_MAX;
    phi    = (quad == 0 || quad == 2) ? rem : QUARTER - rem;
    up     = (quad == 0) || (quad == 3);
    plus   = (quad < 2);
    edge_y = rows_used * BLK;
    cols_w = cols_used * BLK;
    stp    = up ? -BLK : BLK;
    j      = (py / BLK) * BLK + (up ? 0 : BLK);
    dist_v = 0;
    while (1) begin
      t    = up ? py - j : j - py;
      off  = t * longint'(tan_lut[phi]);
      dist_v = (t * longint'(sec_lut[phi])) >>> 8;
      base = px << 16;
      out_left = 0;
      if (plus) i = (base + off) >>> 16;
      else if (base < off + 65536) begin
        i = 0;
        out_left = 1;
      end else i = (base - off) >>> 16;
      if (out_left || i <= 0 || i >= cols_w) break;
      if (j == 0 || j == edge_y) break;
      if (!up && j > edge_y) break;
      if (up) begin
        if (j < edge_y && wall_map[((j - 1) / BLK) * COLS + i / BLK]) break;
      end else begin
        if (wall_map[(j / BLK) * COLS + i / BLK]) break;
      end
      j += stp;
    end
    return (dist_v > longint'(DIST_MAX)) ? DIST_MAX : dist_v[DIST_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (wall_map[k]) wall_map[k] = 0;
      rows_used = ROWS;
      cols_used = COLS;
      dist_q.delete();
      fail_count = 0;
    end else begin
      // config writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAP_ROWS) rows_used = (cfg_data > ROWS) ? ROWS : int'(cfg_data);
        else cols_used = (cfg_data > COLS) ? COLS : int'(cfg_data);
      end
      // result word vs oldest expectation
      if (out_valid) begin
        if (dist_q.size() == 0) begin
          $error("distance: unexpected result %0d", out_distance);
          fail_count++;
        end else begin
          logic [DIST_W-1:0] exp_d;
          exp_d = dist_q.pop_front();
          if (exp_d !== out_distance) begin
            $error("distance: expected %0d, got %0d", exp_d, out_distance);
            fail_count++;
          end
        end
      end
      // accepted input word
      if (start && !busy) begin
        if (in_opcode == OP_CAST)
          dist_q.push_back(grid_distance(longint'(in_pos_x), longint'(in_pos_y),
                                         longint'(in_heading), longint'(in_screen_column)));
        else
          wall_map[int'(in_cell_row) * COLS + int'(in_cell_col)] = in_cell_wall;
      end
    end
  end
endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rhg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_opcode;
  logic [CELL_W-1:0] in_cell_row, in_cell_col;
  logic in_cell_wall;
  logic [POS_W-1:0] in_pos_x, in_pos_y;
  logic [HD_W-1:0] in_heading;
  logic [SC_W-1:0] in_screen_column;
  logic out_valid;
  logic [DIST_W-1:0] out_distance;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int fail_count, dist_pending;
  int cycles = 0;
  bit gaps_on;

  ray_horizontal_grid_hit_top dut (.*);

  rhg_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic idle_burst();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // present one word and hold it until taken
  task automatic send_word(logic op, logic [4:0] row, logic [4:0] col, logic wall,
                           logic [11:0] px, logic [11:0] py, logic [12:0] hd,
                           logic [8:0] sc);
    idle_burst();
    start            <= 1;
    in_opcode        <= op;
    in_cell_row      <= row;
    in_cell_col      <= col;
    in_cell_wall     <= wall;
    in_pos_x         <= px;
    in_pos_y         <= py;
    in_heading       <= hd;
    in_screen_column <= sc;
    do @(posedge clk); while (busy);
  endtask

  task automatic cast(logic [11:0] px, logic [11:0] py, logic [12:0] hd, logic [8:0] sc);
    send_word(OP_CAST, 5'($urandom), 5'($urandom), 1'($urandom), px, py, hd, sc);
  endtask

  task automatic put_cell(logic [4:0] row, logic [4:0] col, logic wall);
    send_word(OP_WRITE, row, col, wall, 12'($urandom), 12'($urandom), 13'($urandom),
              9'($urandom));
  endtask

  // wait until the block is idle and every result is out
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (busy || dist_pending != 0) @(posedge clk);
  endtask

  // register write once the block has drained
  task automatic set_reg(logic idx, logic [CFG_W-1:0] val);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic random_word();
    logic [11:0] px, py;
    logic [12:0] hd;
    if ($urandom_range(0, 9) < 4) begin
      put_cell(5'($urandom), 5'($urandom), $urandom_range(0, 9) < 3);
    end else begin
      px = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2048));
      py = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2048));
      hd = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 5759));
      cast(px, py, hd, 9'($urandom));
    end
  endtask

  initial begin
    int rows_set [6] = '{32, 1, 63, 0, 16, 8};
    int cols_set [6] = '{32, 32, 63, 5, 8, 0};
    gaps_on = 1;
    rst_n = 0;
    start = 0;
    in_opcode = OP_WRITE;
    in_cell_row = 0;
    in_cell_col = 0;
    in_cell_wall = 0;
    in_pos_x = 0;
    in_pos_y = 0;
    in_heading = 0;
    in_screen_column = 0;
    cfg_valid = 0;
    cfg_index = REG_MAP_ROWS;
    cfg_data = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: extremes and special angles
    set_reg(REG_MAP_ROWS, 32);
    set_reg(REG_MAP_COLS, 32);
    put_cell(31, 31, 1);
    put_cell(0, 0, 1);
    put_cell(5, 10, 1);
    put_cell(5, 10, 0);
    put_cell(3, 3, 1);
    cast(1000, 1000, 1440, 0);     // along grid line, 90 deg
    cast(1000, 1000, 4320, 0);     // 270 deg
    cast(1000, 1000, 0, 0);
    cast(1000, 1000, 5759, 319);
    cast(1000, 1000, 8191, 511);   // heading and column wrap
    cast(1000, 1000, 2880, 160);
    cast(0, 0, 100, 0);
    cast(4095, 4095, 3000, 0);     // below map going down
    cast(1000, 4000, 200, 0);      // below map going up
    cast(1000, 4000, 5600, 0);
    cast(1000, 128, 300, 0);       // on a grid line going up
    cast(2047, 2047, 2000, 100);
    cast(230, 230, 4000, 50);
    cast(2000, 100, 700, 0);

    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      set_reg(REG_MAP_ROWS, CFG_W'(rows_set[ph]));
      set_reg(REG_MAP_COLS, CFG_W'(cols_set[ph]));
      if (ph == 5) gaps_on = 0;
      repeat (130) random_word();
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && dist_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
